FILE: hw/rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
// opcodes, status codes, cell and chain control used by the cell, chain and top level
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF     = 128;
  localparam int WORD_BITS_DEF = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LOWER,
    CELL_TAKE_UPPER,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
    logic write_tail;
  } chain_ctrl_t;

endpackage

FILE: hw/rtl/double_ended_queue.sv
// double-ended queue of signed words in two rows of cells, one headed at the front
// and one headed at the back, so both ends sit at fixed cells
// a result appears in the cycle after its item transfers; one item per cycle while out_ready holds
// the output register frees in the cycle its result transfers, so a new item is taken then
// reset (rst_n, synchronous, active low) clears the count, status and output valid; cells keep data
// depends on deq_pkg, deq_chain and deq_cell
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [deq_pkg::OP_W-1:0]      in_opcode,
  input  logic signed [WORD_BITS-1:0]   in_push_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [WORD_BITS-1:0]   out_front_value,
  output logic signed [WORD_BITS-1:0]   out_back_value,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic                          out_is_empty,
  output logic [deq_pkg::STATUS_W-1:0]  out_status
);
  import deq_pkg::*;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  chain_ctrl_t          front_ctrl, back_ctrl;
  logic                 accept;
  logic                 is_full, is_empty;
  logic [WORD_BITS-1:0] front_head, back_head;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    front_ctrl = '0;
    back_ctrl  = '0;
    if (accept) begin
      status_nxt = ST_DONE;
      unique case (in_opcode)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            front_ctrl.shift_in  = 1'b1;
            back_ctrl.write_tail = 1'b1;
            count_nxt            = count_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            back_ctrl.shift_in    = 1'b1;
            front_ctrl.write_tail = 1'b1;
            count_nxt             = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            front_ctrl.shift_out = 1'b1;
            count_nxt            = count_r - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            back_ctrl.shift_out = 1'b1;
            count_nxt           = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  deq_chain #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_front_chain (
    .clk       (clk),
    .ctrl      (front_ctrl),
    .count     (count_r),
    .push_word (in_push_value),
    .head_word (front_head)
  );

  deq_chain #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back_chain (
    .clk       (clk),
    .ctrl      (back_ctrl),
    .count     (count_r),
    .push_word (in_push_value),
    .head_word (back_head)
  );

  assign out_valid       = out_valid_r;
  assign out_front_value = is_empty ? '1 : front_head;
  assign out_back_value  = is_empty ? '1 : back_head;
  assign out_entry_count = count_r;
  assign out_is_empty    = is_empty;
  assign out_status      = status_r;

  // count stays within the store
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
  else $error("entry count beyond depth");

  // a stalled result keeps the queue state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(count_r))
  else $error("state moved while result stalled");

  // a dropped push only happens at full
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_FULL |-> count_r == CNT_W'(DEPTH))
  else $error("full status without full store");

  // a completed push at the front shows up at the front
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_PUSH_FRONT && !is_full
    |=> out_front_value == $past(in_push_value))
  else $error("front push not at front");

  // a completed push at the back shows up at the back
  assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == OP_PUSH_BACK && !is_full
    |=> out_back_value == $past(in_push_value))
  else $error("back push not at back");

endmodule

FILE: hw/rtl/deq_cell.sv
// one storage cell of a chain: holds a word, takes it from a neighbor or loads a new one
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_cell #(
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  deq_pkg::cell_op_t    cell_op,
  input  logic [WORD_BITS-1:0] lower_word,
  input  logic [WORD_BITS-1:0] upper_word,
  input  logic [WORD_BITS-1:0] load_word,
  output logic [WORD_BITS-1:0] word_o
);
  import deq_pkg::*;

  logic [WORD_BITS-1:0] word_r;

  always_ff @(posedge clk) begin
    case (cell_op)
      CELL_TAKE_LOWER: word_r <= lower_word;
      CELL_TAKE_UPPER: word_r <= upper_word;
      CELL_LOAD:       word_r <= load_word;
      default:         word_r <= word_r;
    endcase
  end

  assign word_o = word_r;

endmodule

FILE: hw/rtl/deq_chain.sv
// row of cells with its head at cell 0: inserts at the head, removes from the head,
// or appends at the tail given by the count; depends on deq_pkg and deq_cell
`timescale 1ns / 1ps

module deq_chain #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  deq_pkg::chain_ctrl_t ctrl,
  input  logic [CNT_W-1:0]     count,
  input  logic [WORD_BITS-1:0] push_word,
  output logic [WORD_BITS-1:0] head_word
);
  import deq_pkg::*;

  logic [WORD_BITS-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_op_t             op;
    logic [WORD_BITS-1:0] lower;
    logic [WORD_BITS-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = push_word;
    end else begin : g_mid
      assign lower = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = words[i];
    end else begin : g_inner
      assign upper = words[i+1];
    end

    always_comb begin
      if (ctrl.shift_in) begin
        op = CELL_TAKE_LOWER;
      end else if (ctrl.shift_out) begin
        op = CELL_TAKE_UPPER;
      end else if (ctrl.write_tail && count == CNT_W'(i)) begin
        op = CELL_LOAD;
      end else begin
        op = CELL_HOLD;
      end
    end

    deq_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .cell_op    (op),
      .lower_word (lower),
      .upper_word (upper),
      .load_word  (push_word),
      .word_o     (words[i])
    );
  end

  assign head_word = words[0];

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for double_ended_queue: directed corner cases, then random
// fill / hover / drain phases with random gaps on both channels, checked against a deque model
// depends on deq_pkg and the double_ended_queue rtl
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int TB_DEPTH    = DEPTH_DEF;
  localparam int TB_WORD     = WORD_BITS_DEF;
  localparam int TB_CNT_W    = $clog2(DEPTH_DEF + 1);
  localparam int RANDOM_OPS  = 2000;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [TB_WORD-1:0] front;
    logic signed [TB_WORD-1:0] back;
    logic [TB_CNT_W-1:0]       count;
    logic                      empty;
    logic [STATUS_W-1:0]       status;
  } deque_view_t;

  class deque_scoreboard;
    logic signed [TB_WORD-1:0] word_mem [TB_DEPTH];
    int unsigned head_pos;
    int unsigned fill;
    deque_view_t view_q[$];
    int errors;

    function new();
      head_pos = 0;
      fill = 0;
      errors = 0;
    endfunction

    function void note_transfer(logic [OP_W-1:0] op, logic signed [TB_WORD-1:0] value);
      deque_view_t v;
      v.status = ST_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
        if (fill >= TB_DEPTH) begin
          v.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_pos = (head_pos + TB_DEPTH - 1) % TB_DEPTH;
          word_mem[head_pos] = value;
          fill++;
        end else begin
          word_mem[(head_pos + fill) % TB_DEPTH] = value;
          fill++;
        end
      end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
        if (fill == 0) begin
          v.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) head_pos = (head_pos + 1) % TB_DEPTH;
          fill--;
        end
      end
      if (fill == 0) begin
        v.front = -1;
        v.back  = -1;
      end else begin
        v.front = word_mem[head_pos];
        v.back  = word_mem[(head_pos + fill - 1) % TB_DEPTH];
      end
      v.count = fill[TB_CNT_W-1:0];
      v.empty = (fill == 0);
      view_q.insert(view_q.size(), v);
    endfunction

    function void check_result(deque_view_t got);
      deque_view_t want;
      if (view_q.size() == 0) begin
        $error("result transfer with no operation pending");
        errors++;
        return;
      end
      want = view_q[0];
      view_q.delete(0);
      if (got.front !== want.front) begin
        $error("front_value: expected %0d, got %0d", want.front, got.front);
        errors++;
      end
      if (got.back !== want.back) begin
        $error("back_value: expected %0d, got %0d", want.back, got.back);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending_count();
      return view_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            in_opcode = OP_NONE;
  logic signed [TB_WORD-1:0]  in_push_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [TB_WORD-1:0]  out_front_value;
  logic signed [TB_WORD-1:0]  out_back_value;
  logic [TB_CNT_W-1:0]        out_entry_count;
  logic                       out_is_empty;
  logic [STATUS_W-1:0]        out_status;
  int                         cycles = 0;

  deque_scoreboard sb = new();

  double_ended_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[double_ended_queue] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [TB_WORD-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(TB_WORD-1){1'b1}}};
      1: return {1'b1, {(TB_WORD-1){1'b0}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // push_pct sets the drift toward full or toward empty
  function automatic logic [OP_W-1:0] rand_op(int push_pct);
    int r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      v = $urandom_range(0, 3);
      return (v == 0) ? OP_NONE : OP_W'(OP_POP_BACK + v);
    end
    if (r < 4 + push_pct * 96 / 100)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  task automatic send_op(logic [OP_W-1:0] op, logic signed [TB_WORD-1:0] value);
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(op, value);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side backpressure
  initial begin
    int burst;
    int gap;
    out_ready <= 1'b1;
    forever begin
      burst = $urandom_range(1, 40);
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_front_value, out_back_value, out_entry_count,
                        out_is_empty, out_status});
  end

  initial begin
    int sent;
    int len;
    int phase;
    int pct;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops, idle and unused opcodes, extreme words, single-entry and drain to empty
    send_op(OP_POP_FRONT, rand_word());
    send_op(OP_POP_BACK, rand_word());
    send_op(OP_NONE, rand_word());
    send_op(OP_W'(OP_POP_BACK + 1), rand_word());
    send_op(OP_W'(OP_POP_BACK + 2), rand_word());
    send_op(OP_W'(OP_POP_BACK + 3), rand_word());
    send_op(OP_PUSH_BACK, 32'sh1234_5678);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(OP_PUSH_BACK, 32'sh8000_0000);
    send_op(OP_PUSH_FRONT, -1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, 32'sh5555_5555);
    send_op(OP_PUSH_BACK, 32'shaaaa_aaaa);
    send_op(OP_NONE, '1);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);

    // fill to full, hover there, drain, hover near empty
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_OPS) begin
      len = $urandom_range(150, 350);
      if (len > RANDOM_OPS - sent) len = RANDOM_OPS - sent;
      case (phase % 4)
        0: pct = 80;
        2: pct = 20;
        default: pct = 50;
      endcase
      for (int i = 0; i < len; i++) send_op(rand_op(pct), rand_word());
      sent += len;
      phase++;
    end
    in_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deq_chain.sv
hw/rtl/double_ended_queue.sv
tb/sv/tb_top.sv
